// ===== rtl/core/mbs_pkg.sv =====
// Shared types and constants for the multipart body splitter.
`timescale 1ns / 1ps

package mbs_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 7;
  localparam int LEN_W  = 7;
  localparam int KIND_W = 2;

  // delimiter characters
  localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'd10;
  localparam logic [BYTE_W-1:0] CH_HYPHEN = 8'd45;

  // input function codes
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_BND  = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_HDR_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VAL_BYTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HDR_END  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_VAL_END  = 2'd3;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  pattern_index;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0] out_kind;
    logic [BYTE_W-1:0] out_byte;
  } out_t;

  // result of one processed beat
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  // boundary byte write request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data_byte;
  } bnd_wr_t;

endpackage

// ===== rtl/core/mbs_bnd_mem.sv =====
// Boundary byte store: one write port, one registered read port.
`timescale 1ns / 1ps

module mbs_bnd_mem #(
  parameter int MAX_BOUNDARY = 70
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(MAX_BOUNDARY)-1:0] waddr,
  input  logic [7:0]                      wdata,
  input  logic [$clog2(MAX_BOUNDARY)-1:0] raddr,
  output logic [7:0]                      rdata
);

  logic [7:0] mem_r [MAX_BOUNDARY];
  logic [7:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mbs_delim.sv =====
// Boundary length register, boundary store and the end-aligned value delimiter.
`timescale 1ns / 1ps

module mbs_delim #(
  parameter int MAX_BOUNDARY = 70
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [6:0]                       cfg_len,
  input  mbs_pkg::bnd_wr_t                 bwr,
  output logic [$clog2(MAX_BOUNDARY+1)-1:0] eff_len,
  output logic                             busy,
  output logic [7:0]                       pat [MAX_BOUNDARY+4]
);

  localparam int LW    = $clog2(MAX_BOUNDARY + 1);
  localparam int AW    = $clog2(MAX_BOUNDARY);
  localparam int PD    = MAX_BOUNDARY + 4;
  localparam int PAW   = $clog2(PD);
  localparam int LEN_W = mbs_pkg::LEN_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BOUNDARY);

  typedef enum logic [1:0] {ST_IDLE, ST_FIX, ST_SWEEP} st_t;

  st_t             state_r;
  logic [LEN_W-1:0] len_r;
  logic [LW-1:0]   cnt_r;
  logic [7:0]      pat_r [PD];

  logic [LEN_W-1:0] len7;
  logic [LW-1:0]   raddr_w;
  logic [7:0]      rdata;
  logic            sweep_last;
  logic            mem_we;
  logic            bnd_in_use;
  logic [LEN_W-1:0] pw_full;
  logic [PAW-1:0]  pw_idx;
  logic [PAW-1:0]  fix_base;

  // clamp the programmed length to 1..MAX_BOUNDARY
  always_comb begin
    if (len_r == '0) begin
      eff_len = LW'(1);
    end else if (len_r > LEN_MAX) begin
      eff_len = LW'(MAX_BOUNDARY);
    end else begin
      eff_len = len_r[LW-1:0];
    end
  end

  assign len7     = LEN_W'(eff_len);
  assign fix_base = PAW'(eff_len);

  // boundary writes from the data path; bytes in use also land in the pattern
  assign mem_we     = bwr.en && (bwr.idx < LEN_MAX);
  assign bnd_in_use = bwr.en && (bwr.idx < len7);
  assign pw_full    = len7 - bwr.idx - LEN_W'(1);
  assign pw_idx     = pw_full[PAW-1:0];

  // rebuild sweep reads the store from its last used byte down
  assign sweep_last = (cnt_r == eff_len - LW'(1));
  always_comb begin
    case (state_r)
      ST_FIX:   raddr_w = eff_len - LW'(1);
      ST_SWEEP: raddr_w = sweep_last ? '0 : eff_len - cnt_r - LW'(2);
      default:  raddr_w = '0;
    endcase
  end

  mbs_bnd_mem #(
    .MAX_BOUNDARY(MAX_BOUNDARY)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(bwr.idx[AW-1:0]),
    .wdata(bwr.data_byte),
    .raddr(raddr_w[AW-1:0]),
    .rdata(rdata)
  );

  // rebuild sequencer and pattern register; pattern entry t pairs with the
  // byte t places back from the newest one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FIX;
      cnt_r   <= '0;
      len_r   <= LEN_W'(1);
    end else begin
      if (cfg_we) begin
        len_r <= cfg_len;
      end
      case (state_r)
        ST_FIX: begin
          pat_r[fix_base]            <= mbs_pkg::CH_HYPHEN;
          pat_r[fix_base + PAW'(1)]  <= mbs_pkg::CH_HYPHEN;
          pat_r[fix_base + PAW'(2)]  <= mbs_pkg::CH_LF;
          pat_r[fix_base + PAW'(3)]  <= mbs_pkg::CH_CR;
          cnt_r   <= '0;
          state_r <= ST_SWEEP;
        end
        ST_SWEEP: begin
          pat_r[PAW'(cnt_r)] <= rdata;
          cnt_r <= cnt_r + LW'(1);
          if (sweep_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (bnd_in_use) begin
            pat_r[pw_idx] <= bwr.data_byte;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      // a new length restarts the rebuild
      if (cfg_we) begin
        state_r <= ST_FIX;
      end
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign pat  = pat_r;

endmodule

// ===== rtl/core/mbs_window.sv =====
// Hold-back window, delimiter match and phase tracking for body beats.
`timescale 1ns / 1ps

module mbs_window #(
  parameter int MAX_BOUNDARY = 70
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [7:0]                       din,
  input  logic [$clog2(MAX_BOUNDARY+1)-1:0] eff_len,
  input  logic [7:0]                       pat [MAX_BOUNDARY+4],
  output mbs_pkg::res_t                    res
);

  localparam int HD  = MAX_BOUNDARY + 3;   // held bytes at most
  localparam int TD  = MAX_BOUNDARY + 3;   // newest-first copy for matching
  localparam int FW  = $clog2(MAX_BOUNDARY + 4);
  localparam int HAW = $clog2(HD);

  logic          phase_r;
  logic [FW-1:0] fill_r;
  logic [7:0]    head_r [HD];   // oldest byte at 0
  logic [7:0]    tail_r [TD];   // newest held byte at 0

  logic [FW-1:0] dm1;
  logic          reach;
  logic          m0;
  logic          m1;
  logic [TD-1:0] ok_v;
  logic          hit;
  logic          rel;
  logic [FW-1:0] fill_m1;
  logic [FW-1:0] wr_full;
  logic [HAW-1:0] wr_idx;

  // delimiter length less one: CR LF CR LF, or CR LF -- boundary
  assign dm1   = phase_r ? FW'(eff_len) + FW'(3) : FW'(3);
  assign reach = (fill_r >= dm1);

  // header delimiter
  assign m0 = (din == mbs_pkg::CH_LF) && (tail_r[0] == mbs_pkg::CH_CR) &&
              (tail_r[1] == mbs_pkg::CH_LF) && (tail_r[2] == mbs_pkg::CH_CR);

  // value delimiter against the end-aligned pattern
  always_comb begin
    for (int j = 0; j < TD; j++) begin
      ok_v[j] = (FW'(j) >= dm1) || (tail_r[j] == pat[j+1]);
    end
  end
  assign m1 = (din == pat[0]) && (&ok_v);

  assign hit = reach && (phase_r ? m1 : m0);
  assign rel = reach && !hit;

  assign fill_m1 = fill_r - FW'(1);
  assign wr_full = rel ? fill_m1 : fill_r;
  assign wr_idx  = wr_full[HAW-1:0];

  // phase and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      fill_r  <= '0;
    end else if (step) begin
      if (hit) begin
        phase_r <= ~phase_r;
        fill_r  <= '0;
      end else if (!rel) begin
        fill_r <= fill_r + FW'(1);
      end
    end
  end

  // held bytes: shift out the oldest on release, append the new one
  always_ff @(posedge clk) begin
    if (step && !hit) begin
      if (rel) begin
        for (int i = 0; i < HD - 1; i++) begin
          head_r[i] <= head_r[i+1];
        end
      end
      head_r[wr_idx] <= din;
      tail_r[0] <= din;
      for (int j = 1; j < TD; j++) begin
        tail_r[j] <= tail_r[j-1];
      end
    end
  end

  // result of this beat
  always_comb begin
    res.valid = step && (hit || rel);
    if (hit) begin
      res.data.out_kind = phase_r ? mbs_pkg::KIND_VAL_END : mbs_pkg::KIND_HDR_END;
      res.data.out_byte = '0;
    end else begin
      res.data.out_kind = phase_r ? mbs_pkg::KIND_VAL_BYTE : mbs_pkg::KIND_HDR_BYTE;
      res.data.out_byte = head_r[0];
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HD))
    else $error("window fill beyond its depth");

  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && hit |=> (fill_r == '0) && (phase_r != $past(phase_r)))
    else $error("delimiter did not clear window and flip phase");

  a_rel_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    step && rel |=> $stable(fill_r) && $stable(phase_r))
    else $error("release changed fill or phase");

  a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && !hit && !rel |=> (fill_r == $past(fill_r) + FW'(1)))
    else $error("held beat did not grow the window");

endmodule

// ===== rtl/core/multipart_body_splitter.sv =====
// Top level of the multipart body splitter: handshakes, beat and result registers.
//
//  channel | dir | handshake       | beat
//  --------+-----+-----------------+------------------------------------------
//  in_     | in  | in_valid/stall  | mbs_pkg::in_t  (func, data_byte, index)
//  out_    | out | out_valid/stall | mbs_pkg::out_t (out_kind, out_byte)
//  cfg_    | in  | cfg_valid/ready | boundary_len, 7 bits
//
// One beat per cycle unless out_stall or a pattern rebuild holds the pipe; a result is
// registered when its beat leaves the input beat register. The window compare sits in
// one pass between the input and result registers. After reset and after each
// boundary_len write, in_stall is high while the delimiter pattern is rebuilt from the
// boundary store, one byte per cycle over the clamped length (1..MAX_BOUNDARY).
// cfg_ready is always high. A stalled result holds its register; the input side keeps
// taking beats while the result register is being emptied in the same cycle.
`timescale 1ns / 1ps

module multipart_body_splitter #(
  parameter int MAX_BOUNDARY = 70
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mbs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mbs_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [6:0]    cfg_data
);

  localparam int LW = $clog2(MAX_BOUNDARY + 1);

  logic             in_v_r;
  mbs_pkg::in_t     in_d_r;
  logic             out_v_r;
  mbs_pkg::out_t    out_d_r;

  logic             busy;
  logic             adv;
  logic             step_any;
  logic             step_data;
  logic             cfg_we;
  mbs_pkg::bnd_wr_t bwr;
  mbs_pkg::res_t    res;
  logic [LW-1:0]    eff_len;
  logic [7:0]       pat [MAX_BOUNDARY+4];

  // pipeline control
  assign adv       = (!out_v_r || !out_stall) && !busy;
  assign step_any  = in_v_r && adv;
  assign step_data = step_any && (in_d_r.func == mbs_pkg::FUNC_DATA);
  assign in_stall  = busy || (in_v_r && !adv);

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // boundary byte writes
  assign bwr.en        = step_any && (in_d_r.func == mbs_pkg::FUNC_BND);
  assign bwr.idx       = in_d_r.pattern_index;
  assign bwr.data_byte = in_d_r.data_byte;

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_d_r <= in_data;
    end
  end

  mbs_delim #(
    .MAX_BOUNDARY(MAX_BOUNDARY)
  ) u_delim (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_we),
    .cfg_len(cfg_data),
    .bwr    (bwr),
    .eff_len(eff_len),
    .busy   (busy),
    .pat    (pat)
  );

  mbs_window #(
    .MAX_BOUNDARY(MAX_BOUNDARY)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step_data),
    .din    (in_d_r.data_byte),
    .eff_len(eff_len),
    .pat    (pat),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_any) begin
      out_v_r <= res.valid;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_any && res.valid) begin
      out_d_r <= res.data;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// ===== bench/multipart_body_splitter_tb.sv =====
// Self-checking bench for the multipart body splitter: random bursts, delimiter checks.
`timescale 1ns / 1ps

module multipart_body_splitter_tb;

  localparam int MAX_BOUNDARY   = 70;
  localparam int PHASE_ITEMS    = 60;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 3000;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  mbs_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  mbs_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [6:0]    cfg_data  = '0;

  // beats waiting for the driver, results waiting for the monitor
  mbs_pkg::in_t  pend[$];
  mbs_pkg::out_t split_expected[$];
  int   n_queued = 0;
  int   n_taken  = 0;
  int   n_items  = 0;
  int   err_cnt  = 0;

  // predictor state
  bit         mdl_value   = 1'b0;
  logic [7:0] held[$];
  logic [7:0] bnd_mem [MAX_BOUNDARY];
  logic [6:0] bnd_len_reg = 7'd1;

  // stimulus-side view of the stream
  bit         gen_value = 1'b0;
  int         gen_len   = 1;
  logic [7:0] gen_bnd [MAX_BOUNDARY];

  // idle control
  int in_idle_odds  = 0;
  int out_idle_odds = 0;
  int in_gap        = 0;
  int out_hold      = 0;
  int idle_cycles   = 0;

  multipart_body_splitter #(
    .MAX_BOUNDARY(MAX_BOUNDARY)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // boundary length as the matcher sees it
  function automatic int eff_len(logic [6:0] v);
    if (v == 0) return 1;
    if (v > MAX_BOUNDARY) return MAX_BOUNDARY;
    return v;
  endfunction

  // k-th delimiter byte: CR LF CR LF in headers, CR LF -- boundary in values
  function automatic logic [7:0] delim_char(bit value_side, int k,
                                             logic [7:0] bnd [MAX_BOUNDARY]);
    if (k == 0) return mbs_pkg::CH_CR;
    if (k == 1) return mbs_pkg::CH_LF;
    if (!value_side) return (k == 2) ? mbs_pkg::CH_CR : mbs_pkg::CH_LF;
    if (k < 4) return mbs_pkg::CH_HYPHEN;
    return bnd[k-4];
  endfunction

  // window match on one accepted beat; queues the result it releases
  function automatic void predict_split(mbs_pkg::in_t beat);
    int            dlen;
    int            pos;
    bit            hit;
    mbs_pkg::out_t res;
    logic [7:0]    c;
    n_taken++;
    if (beat.func == mbs_pkg::FUNC_BND) begin
      if (beat.pattern_index < MAX_BOUNDARY) bnd_mem[beat.pattern_index] = beat.data_byte;
      return;
    end
    dlen = mdl_value ? 4 + eff_len(bnd_len_reg) : 4;
    hit  = (held.size() + 1 >= dlen);
    for (int k = 0; k < dlen && hit; k++) begin
      pos = held.size() + 1 - dlen + k;
      c   = (pos < held.size()) ? held[pos] : beat.data_byte;
      if (c != delim_char(mdl_value, k, bnd_mem)) hit = 1'b0;
    end
    res.out_byte = '0;
    if (hit) begin
      res.out_kind = mdl_value ? mbs_pkg::KIND_VAL_END : mbs_pkg::KIND_HDR_END;
      held.delete();
      mdl_value = !mdl_value;
      split_expected.push_back(res);
    end else if (held.size() >= dlen - 1 && held.size() > 0) begin
      // oldest held byte falls out; surplus bytes drain one per beat
      res.out_kind = mdl_value ? mbs_pkg::KIND_VAL_BYTE : mbs_pkg::KIND_HDR_BYTE;
      res.out_byte = held.pop_front();
      held.push_back(beat.data_byte);
      split_expected.push_back(res);
    end else begin
      held.push_back(beat.data_byte);
    end
  endfunction

  function automatic void flag_mismatch(string what, mbs_pkg::out_t want,
                                        mbs_pkg::out_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("ERROR @%0t: %s: expected kind %0d byte %02h, got kind %0d byte %02h",
               $realtime, what, want.out_kind, want.out_byte, got.out_kind, got.out_byte);
  endfunction

  function automatic void check_split(mbs_pkg::out_t got);
    mbs_pkg::out_t want;
    if (split_expected.size() == 0) begin
      flag_mismatch("result with nothing pending", '0, got);
      return;
    end
    want = split_expected.pop_front();
    if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte)
      flag_mismatch("wrong result", want, got);
  endfunction

  // input driver: beats from the pending queue, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) predict_split(in_data);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pend.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pend.pop_front();
          if (in_idle_odds > 0 && $urandom_range(1, in_idle_odds) == 1)
            in_gap <= $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      if (out_valid && !out_stall) check_split(out_data);
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold  <= out_hold - 1;
      end else if (out_idle_odds > 0 && $urandom_range(1, out_idle_odds) == 1) begin
        out_stall <= 1'b1;
        out_hold  <= $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long without any beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus helpers
  task automatic queue_beat(logic fn, logic [7:0] b, logic [6:0] idx);
    mbs_pkg::in_t beat;
    beat.func          = fn;
    beat.data_byte     = b;
    beat.pattern_index = idx;
    pend.push_back(beat);
    n_queued++;
    if (fn == mbs_pkg::FUNC_DATA || idx < MAX_BOUNDARY) n_items++;
    if (fn == mbs_pkg::FUNC_BND && idx < MAX_BOUNDARY) gen_bnd[idx] = b;
  endtask

  task automatic send_byte(logic [7:0] b);
    queue_beat(mbs_pkg::FUNC_DATA, b, 7'($urandom_range(0, 127)));
  endtask

  function automatic int gen_dlen();
    return gen_value ? 4 + gen_len : 4;
  endfunction

  // first cnt delimiter bytes; a complete one flips the side
  task automatic send_delim(int cnt);
    int full;
    full = gen_dlen();
    for (int k = 0; k < cnt; k++) send_byte(delim_char(gen_value, k, gen_bnd));
    if (cnt == full) gen_value = !gen_value;
  endtask

  // body content with the odd broken delimiter, raw byte or boundary rewrite
  task automatic send_filler(int cnt);
    int pick;
    int p;
    for (int i = 0; i < cnt; i++) begin
      pick = $urandom_range(0, 31);
      if (pick == 0) begin
        queue_beat(mbs_pkg::FUNC_BND, 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)));
      end else if (pick == 1) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick == 2) begin
        p = $urandom_range(1, gen_dlen() - 1);
        send_delim(p);
        send_byte(delim_char(gen_value, p, gen_bnd) ^ 8'h01);
      end else begin
        send_byte(8'($urandom_range(32, 126)));
      end
    end
  endtask

  task automatic load_boundary(int cnt);
    logic [7:0] b;
    for (int i = 0; i < cnt; i++) begin
      b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(33, 126));
      queue_beat(mbs_pkg::FUNC_BND, b, 7'(i));
    end
  endtask

  // all beats taken, all results back, pipeline settled
  task automatic wait_quiet();
    @(posedge clk);
    while (n_taken != n_queued || split_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_blen(logic [6:0] v);
    wait_quiet();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    bnd_len_reg = v;
  endtask

  // stimulus and end of run
  initial begin
    int plan[$];
    int idle_pick[3];
    int start;
    bit tail_value;
    idle_pick = '{0, 3, 10};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: boundary writes in and out of range, header and value edges
    in_idle_odds  = 3;
    out_idle_odds = 3;
    queue_beat(mbs_pkg::FUNC_BND, 8'h51, 7'd0);
    queue_beat(mbs_pkg::FUNC_BND, mbs_pkg::CH_CR, 7'd127);
    queue_beat(mbs_pkg::FUNC_BND, 8'hFF, 7'd70);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_delim(3);
    send_byte(8'h7F);
    send_delim(4);
    send_byte(8'hFF);
    send_delim(4);
    send_byte(8'h50);
    send_delim(5);
    send_delim(4);

    // length settings: extremes first, then random ones
    plan = '{70, 0, 127, 1, 2};
    repeat (5) plan.push_back($urandom_range(1, 12));
    plan.push_back($urandom_range(13, 69));
    plan.push_back($urandom_range(71, 126));

    foreach (plan[p]) begin
      if (p == 0) load_boundary(MAX_BOUNDARY);
      else if ($urandom_range(0, 1) == 1) load_boundary(eff_len(7'(plan[p])));
      write_blen(7'(plan[p]));
      gen_len = eff_len(7'(plan[p]));
      if (p == plan.size() - 1) begin
        in_idle_odds  = 0;
        out_idle_odds = 0;
      end else begin
        in_idle_odds  = idle_pick[$urandom_range(0, 2)];
        out_idle_odds = idle_pick[$urandom_range(0, 2)];
      end

      // well-formed parts with random content
      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        send_filler(gen_value ? $urandom_range(0, 30) : $urandom_range(0, 12));
        send_delim(gen_dlen());
      end

      // leave bytes held across the length change, long ones after the widest boundary
      tail_value = (gen_len == MAX_BOUNDARY) || ($urandom_range(0, 2) != 0);
      if (tail_value && !gen_value) begin
        send_filler($urandom_range(0, 8));
        send_delim(gen_dlen());
      end
      if (gen_value) send_filler($urandom_range(gen_len + 5, gen_len + 20));
      else send_filler($urandom_range(0, 6));
    end

    wait_quiet();
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
